// File: hw/rtl/srs_pkg.sv
// Shared types and constants for the substring replace stream block.
`default_nettype none

package srs_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BYTE_W          = 8;
    localparam int WIN_IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W           = 4;
    localparam int BURST_BYTES     = 8;
    localparam int BURST_W         = BURST_BYTES * BYTE_W;
    localparam int PAT_W           = MAX_PATTERN * BYTE_W;
    localparam int REP_W           = MAX_REPLACEMENT * BYTE_W;
    localparam int LIMIT_W         = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = FIFO_PTR_W + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_LIMIT_ENABLE       = 3'd4,
        CFG_REPLACE_LIMIT      = 3'd5
    } t_cfg_idx;

    // One burst of results caused by one input transaction.
    // cnt of zero with last set means a single end marker.
    typedef struct packed {
        logic [BURST_W-1:0] data;
        logic [CNT_W-1:0]   cnt;
        logic               last;
    } t_burst;

endpackage

`default_nettype wire

// File: hw/rtl/srs_front.sv
// Front end: configuration registers, match window and burst classification.
`default_nettype none

module srs_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [srs_pkg::BYTE_W-1:0]      i_in_byte,
    input  logic                            i_byte_present,
    input  logic                            i_string_last,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output srs_pkg::t_burst                 o_q_data
);
    import srs_pkg::*;

    // configuration
    logic [PAT_W-1:0]   r_pat;
    logic [CNT_W-1:0]   r_plen;
    logic [REP_W-1:0]   r_rep;
    logic [CNT_W-1:0]   r_rlen;
    logic               r_lim_en;
    logic [LIMIT_W-1:0] r_limit;

    // window state
    logic [BYTE_W-1:0]    r_win [MAX_PATTERN];
    logic [BYTE_W-1:0]    n_win [MAX_PATTERN];
    logic [WIN_IDX_W-1:0] r_fill;
    logic [WIN_IDX_W-1:0] n_fill;
    logic [LIMIT_W-1:0]   r_done;
    logic [LIMIT_W-1:0]   n_done;

    logic [BYTE_W-1:0]  w_ext [MAX_PATTERN];
    logic [PAT_W-1:0]   ext_flat;
    logic [CNT_W-1:0]   plen_eff;
    logic [CNT_W-1:0]   rlen_eff;
    logic [CNT_W-1:0]   fill_ext;
    logic               compared;
    logic               match;
    logic               allowed;
    logic               replace;
    logic               shift;
    logic               accept;
    logic [CNT_W-1:0]   burst_cnt;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // effective lengths
    always_comb begin
        if (r_plen == '0) begin
            plen_eff = CNT_W'(1);
        end else if (r_plen > CNT_W'(MAX_PATTERN)) begin
            plen_eff = CNT_W'(MAX_PATTERN);
        end else begin
            plen_eff = r_plen;
        end
        rlen_eff = (r_rlen > CNT_W'(MAX_REPLACEMENT)) ? CNT_W'(MAX_REPLACEMENT) : r_rlen;
    end

    // window with the incoming byte placed at the fill position
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (i_byte_present && (r_fill == WIN_IDX_W'(k))) begin
                w_ext[k] = i_in_byte;
            end else begin
                w_ext[k] = r_win[k];
            end
            ext_flat[k*BYTE_W +: BYTE_W] = w_ext[k];
        end
    end

    // pattern compare, one lane per window byte
    always_comb begin
        match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((CNT_W'(k) < plen_eff) && (w_ext[k] != r_pat[k*BYTE_W +: BYTE_W])) begin
                match = 1'b0;
            end
        end
    end

    assign fill_ext = {1'b0, r_fill} + {{(CNT_W-1){1'b0}}, i_byte_present};
    assign compared = i_byte_present && (fill_ext >= plen_eff);
    assign allowed  = !r_lim_en || (r_done < r_limit);
    assign replace  = compared && match && allowed;
    assign shift    = compared && !replace;

    // burst description for the back end
    always_comb begin
        if (replace) begin
            burst_cnt = rlen_eff;
        end else if (i_string_last) begin
            burst_cnt = fill_ext;
        end else if (shift) begin
            burst_cnt = CNT_W'(1);
        end else begin
            burst_cnt = '0;
        end
        o_q_data.data = replace ? r_rep : ext_flat;
        o_q_data.cnt  = burst_cnt;
        o_q_data.last = i_string_last;
        o_q_push      = accept && ((burst_cnt != '0) || i_string_last);
    end

    // next window contents
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (shift && (k < MAX_PATTERN - 1)) begin
                n_win[k] = w_ext[(k + 1) % MAX_PATTERN];
            end else begin
                n_win[k] = w_ext[k];
            end
        end
    end

    // next fill level and replacement count
    always_comb begin
        n_fill = r_fill;
        n_done = r_done;
        if (i_string_last) begin
            n_fill = '0;
            n_done = '0;
        end else if (replace) begin
            n_fill = '0;
            if (r_done != {LIMIT_W{1'b1}}) begin
                n_done = r_done + LIMIT_W'(1);
            end
        end else if (shift) begin
            n_fill = r_fill;
        end else if (i_byte_present) begin
            n_fill = fill_ext[WIN_IDX_W-1:0];
        end
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat    <= '0;
            r_plen   <= CNT_W'(1);
            r_rep    <= '0;
            r_rlen   <= '0;
            r_lim_en <= 1'b0;
            r_limit  <= '0;
            r_fill   <= '0;
            r_done   <= '0;
        end else begin
            if (accept) begin
                r_fill <= n_fill;
                r_done <= n_done;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_PATTERN_BYTES: begin
                        r_pat <= i_cfg_data[PAT_W-1:0];
                    end
                    CFG_PATTERN_LENGTH: begin
                        r_plen <= i_cfg_data[CNT_W-1:0];
                        r_fill <= '0;
                    end
                    CFG_REPLACEMENT_BYTES: begin
                        r_rep <= i_cfg_data[REP_W-1:0];
                    end
                    CFG_REPLACEMENT_LENGTH: begin
                        r_rlen <= i_cfg_data[CNT_W-1:0];
                    end
                    CFG_LIMIT_ENABLE: begin
                        r_lim_en <= i_cfg_data[0];
                    end
                    CFG_REPLACE_LIMIT: begin
                        r_limit <= i_cfg_data[LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // window bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/srs_fifo.sv
// Short burst queue between the front and back ends.
`default_nettype none

module srs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  srs_pkg::t_burst i_data,
    input  logic            i_pop,
    output srs_pkg::t_burst o_head,
    output logic            o_full,
    output logic            o_empty
);
    import srs_pkg::*;

    t_burst                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/srs_back.sv
// Back end: serialises each burst into result transactions via an output register.
`default_nettype none

module srs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srs_pkg::t_burst             i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [srs_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_out_valid,
    output logic                        o_run_last,
    output logic                        o_string_end
);
    import srs_pkg::*;

    localparam int IDX_W = $clog2(BURST_BYTES);

    logic [IDX_W-1:0]  r_idx;
    logic              r_res_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_valid;
    logic              r_run_last;
    logic              r_string_end;

    logic              load;
    logic              is_marker;
    logic              final_byte;
    logic [BYTE_W-1:0] sel_byte;

    // pick the next byte of the head burst
    assign load       = !i_empty && (!r_res_valid || !i_res_stall);
    assign is_marker  = (i_head.cnt == '0);
    assign final_byte = is_marker || (({1'b0, r_idx} + CNT_W'(1)) == i_head.cnt);
    assign sel_byte   = is_marker ? '0 : i_head.data[{r_idx, 3'b000} +: BYTE_W];
    assign o_pop      = load && final_byte;

    // byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (load) begin
                r_res_valid <= 1'b1;
                r_idx       <= final_byte ? '0 : r_idx + IDX_W'(1);
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= sel_byte;
            r_out_valid  <= !is_marker;
            r_run_last   <= final_byte;
            r_string_end <= final_byte && i_head.last;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_valid  = r_out_valid;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_string_end;

endmodule

`default_nettype wire

// File: hw/rtl/substring_replace_stream_core.sv
// Top level of the substring replace stream block.
//
// Usage: source bytes arrive on the input channel (i_in_valid / o_in_stall),
// one byte per transaction with i_byte_present and i_string_last. A
// transaction with i_byte_present low and i_string_last high closes an
// empty string. Result bytes leave on the output channel (o_res_valid /
// i_res_stall); o_run_last closes the results of one input transaction,
// o_string_end closes the result string, and an empty result string gives
// one marker with o_out_valid low. Leftmost non-overlapping matches of the
// pattern are swapped for the replacement, up to the optional limit.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle.
// The first result is registered in the burst queue and then in the output register.
// Throughput: one input transaction per cycle while each causes at most
// one result and i_res_stall is low; the back end emits the results of
// a transaction causing k results one byte per cycle when unstalled. A four
// entry burst queue absorbs the longer bursts before o_in_stall rises.
// Reset clears the window fill level, counters, queue and output valid
// and loads the register defaults. A stall on the output holds the result
// register; the queue then fills and stalls the input.
`default_nettype none

module substring_replace_stream_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [srs_pkg::BYTE_W-1:0]      i_in_byte,
    input  logic                            i_byte_present,
    input  logic                            i_string_last,
    output logic                            o_res_valid,
    input  logic                            i_res_stall,
    output logic [srs_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_out_valid,
    output logic                            o_run_last,
    output logic                            o_string_end
);
    import srs_pkg::*;

    t_burst q_in;
    t_burst q_head;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    // classify and build bursts
    srs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_string_last  (i_string_last),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    // burst queue
    srs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // serialise bursts
    srs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_out_byte   (o_out_byte),
        .o_out_valid  (o_out_valid),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    // checks
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid straight after reset");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_string_end |-> o_run_last)
        else $error("string end without run end");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_out_valid |-> o_string_end && (o_out_byte == '0))
        else $error("marker result malformed");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("burst pushed into a full queue");

endmodule

`default_nettype wire
